// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ----- src/aes_pkg.sv -----
// aes-128 package: sbox table, round helpers, shared types
// no dependencies
`timescale 1ns / 1ps
package aes_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumRk = NumRounds + 1;
  localparam logic [4:0] FullCount = 5'd16;

  typedef logic [127:0] state_t;

  typedef struct packed {
    logic       valid;
    logic       final_out;
    logic [127:0] data;
  } beat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input state_t s, input int unsigned i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes + shiftrows, then mixcolumns unless last round
  function automatic state_t round_fn(input state_t s, input logic last);
    state_t t;
    state_t m;
    logic [7:0] a0, a1, a2, a3, x;
    t = '0;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, c*4);
      a1 = get_byte(t, c*4+1);
      a2 = get_byte(t, c*4+2);
      a3 = get_byte(t, c*4+3);
      x = a0 ^ a1 ^ a2 ^ a3;
      m[127 - 8*(c*4) -: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
      m[127 - 8*(c*4+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      m[127 - 8*(c*4+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      m[127 - 8*(c*4+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    round_fn = last ? t : m;
  endfunction

  // one key schedule step: next round key from previous
  function automatic state_t key_step(input state_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction
endpackage

// ----- src/aes_key_exp.sv -----
// key expansion: one round key per cycle into a register file
// depends on aes_pkg
`timescale 1ns / 1ps
module aes_key_exp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [127:0]         key_i,
  output logic [127:0]         rk_o [aes_pkg::NumRk],
  output logic                 busy_o
);
  logic [127:0] rk_q [aes_pkg::NumRk];
  logic [3:0]   idx_q, idx_d;
  logic         busy_q, busy_d;
  logic         init_q;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (start_i || !init_q) begin
      idx_d  = 4'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (idx_q == 4'(aes_pkg::NumRounds)) busy_d = 1'b0;
      else idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 4'd1;
      busy_q <= 1'b1;
      init_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
      init_q <= 1'b1;
    end
  end

  // key 0 loads directly; later keys built one per cycle
  always_ff @(posedge clk_i) begin
    if (start_i || !init_q) begin
      rk_q[0] <= key_i;
    end else if (busy_q) begin
      rk_q[idx_q] <= aes_pkg::key_step(rk_q[idx_q - 4'd1], aes_pkg::RCON[idx_q]);
    end
  end

  assign rk_o   = rk_q;
  assign busy_o = busy_q;
endmodule

// ----- src/aes_round_stage.sv -----
// one aes round with its pipeline register and stall control
// depends on aes_pkg
`timescale 1ns / 1ps
module aes_round_stage #(
  parameter bit LastRound = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  aes_pkg::beat_t  beat_i,
  input  logic [127:0]    rk_i,
  output aes_pkg::beat_t  beat_o
);
  logic valid_q;
  logic final_q;
  logic [127:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      final_q <= beat_i.final_out;
      data_q  <= aes_pkg::round_fn(beat_i.data, LastRound) ^ rk_i;
    end
  end

  assign beat_o = '{valid: valid_q, final_out: final_q, data: data_q};
endmodule

// ----- src/aes128_ecb_pkcs7_encrypt.sv -----
// aes-128 ecb encrypt with pkcs7 padding, top level
// depends on aes_pkg, aes_key_exp, aes_round_stage, assert_macros.svh
// input beat to output beat passes the pad register, 10 round registers and the out reg
// throughput: one beat per cycle while the output is taken and no key expansion runs;
//   a full last block holds input off while the appended all-0x10 block enters
// key writes restart the key expansion; input is held off meanwhile
// reset: async active low, clears valids and loads the all-zero key
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes128_ecb_pkcs7_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  output logic        final_out_o
);
  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  logic [63:0]  key_high_q, key_low_q;
  logic [127:0] rk [aes_pkg::NumRk];
  logic         kx_busy;
  logic         kx_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      kx_start_q <= 1'b0;
    end else begin
      kx_start_q <= cfg_we_i;
      if (cfg_we_i && cfg_idx_i == RegKeyHigh) key_high_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == RegKeyLow)  key_low_q  <= cfg_data_i;
    end
  end

  aes_key_exp u_kx (
    .clk_i,
    .rst_ni,
    .start_i (kx_start_q),
    .key_i   ({key_high_q, key_low_q}),
    .rk_o    (rk),
    .busy_o  (kx_busy)
  );

  // pipeline advances unless the output register holds an untaken beat
  aes_pkg::beat_t stg [aes_pkg::NumRk];
  aes_pkg::beat_t stage0_q;
  aes_pkg::beat_t out_q;
  logic           adv;
  assign adv = !out_q.valid || out_ready_i;

  // extra pad block pending after a full final block
  logic extra_q;
  logic in_fire;
  logic stage0_load;
  assign in_ready_o  = adv && !extra_q && !kx_busy && !kx_start_q && !cfg_we_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign stage0_load = adv && (extra_q || in_fire);

  // padding and initial key xor
  logic [127:0] padded;
  logic [4:0]   cnt;
  logic [7:0]   pad;
  logic         full_last;
  always_comb begin
    cnt = (byte_count_i > aes_pkg::FullCount) ? aes_pkg::FullCount : byte_count_i;
    pad = 8'(aes_pkg::FullCount - cnt);
    full_last = last_block_i && (cnt == aes_pkg::FullCount);
    padded = {block_high_i, block_low_i};
    if (extra_q) begin
      padded = {16{8'h10}};
    end else if (last_block_i) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= cnt) padded[127 - 8*i -: 8] = pad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_q  <= 1'b0;
      stage0_q <= '0;
    end else if (adv) begin
      stage0_q.valid     <= stage0_load;
      stage0_q.data      <= padded ^ rk[0];
      stage0_q.final_out <= extra_q || (last_block_i && !full_last);
      if (extra_q) extra_q <= 1'b0;
      else if (in_fire && full_last) extra_q <= 1'b1;
    end
  end

  assign stg[0] = stage0_q;

  for (genvar r = 1; r < aes_pkg::NumRk; r++) begin : g_round
    aes_round_stage #(.LastRound(r == aes_pkg::NumRounds)) u_round (
      .clk_i,
      .rst_ni,
      .en_i   (adv),
      .beat_i (stg[r-1]),
      .rk_i   (rk[r]),
      .beat_o (stg[r])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv) begin
      out_q <= stg[aes_pkg::NumRounds];
    end
  end

  assign out_valid_o   = out_q.valid;
  assign cipher_high_o = out_q.data[127:64];
  assign cipher_low_o  = out_q.data[63:0];
  assign final_out_o   = out_q.final_out;

  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cipher_high_o)),
    "output beat dropped while stalled")
  `ASSERT_NEVER(a_no_accept_in_kx, clk_i, rst_ni, in_fire && kx_busy,
    "input accepted during key expansion")
  `ASSERT_IMPL(a_extra_follows, clk_i, rst_ni,
    (in_fire && full_last) |=> (extra_q && !in_ready_o),
    "pad block not scheduled after full final block")
endmodule

// ----- tb/aes128_ecb_pkcs7_check.sv -----
// checker for the aes-128 ecb pkcs7 encrypter: shadow key schedule, expected
// ciphertext queue and field compare; depends only on the block's port list
`timescale 1ns / 1ps
package aes_tb_pkg;
  localparam logic [0:0] KeyHighIdx = 1'b0;
  localparam logic [0:0] KeyLowIdx  = 1'b1;
endpackage

module aes128_ecb_pkcs7_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_block_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] cipher_high_i,
  input  logic [63:0] cipher_low_i,
  input  logic        final_out_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);
  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        fin;
  } cipher_beat_t;

  cipher_beat_t cipher_q[$];
  logic [7:0]   sub_tab[256];
  logic [63:0]  key_hi, key_lo;
  logic [127:0] round_keys[11];

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  // sbox built from the field inverse plus the affine map
  initial begin
    logic [7:0] inv, b;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gmul(inv, v[7:0]);
      if (v == 0) inv = 8'h00;
      b = inv;
      for (int r = 1; r < 5; r++) b ^= (inv << r) | (inv >> (8 - r));
      sub_tab[v] = b ^ 8'h63;
    end
  end

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic void expand_schedule();
    logic [31:0] w[44];
    logic [31:0] t;
    logic [7:0]  rc;
    {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sub_tab[t[23:16]] ^ rc, sub_tab[t[15:8]], sub_tab[t[7:0]], sub_tab[t[31:24]]};
        rc = dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] cipher_of(input logic [127:0] pt);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3, x;
    s = pt ^ round_keys[0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8*(c*4+r) -: 8] = sub_tab[byte_at(s, ((c + r) % 4) * 4 + r)];
      s = t;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = byte_at(t, c*4);   a1 = byte_at(t, c*4+1);
          a2 = byte_at(t, c*4+2); a3 = byte_at(t, c*4+3);
          x = a0 ^ a1 ^ a2 ^ a3;
          s[127 - 8*(c*4) -: 8]   = a0 ^ x ^ dbl(a0 ^ a1);
          s[127 - 8*(c*4+1) -: 8] = a1 ^ x ^ dbl(a1 ^ a2);
          s[127 - 8*(c*4+2) -: 8] = a2 ^ x ^ dbl(a2 ^ a3);
          s[127 - 8*(c*4+3) -: 8] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      s ^= round_keys[rnd];
    end
    return s;
  endfunction

  function automatic void predict_ciphertext(input logic [127:0] pt, input logic [4:0] cnt,
                                             input logic last);
    cipher_beat_t e;
    logic [127:0] c;
    int n;
    n = (cnt > 16) ? 16 : cnt;
    if (last && n < 16)
      for (int i = n; i < 16; i++) pt[127 - 8*i -: 8] = 8'(16 - n);
    c = cipher_of(pt);
    e.hi = c[127:64]; e.lo = c[63:0]; e.fin = last && n < 16;
    cipher_q.push_back(e);
    if (last && n == 16) begin
      c = cipher_of({16{8'h10}});
      e.hi = c[127:64]; e.lo = c[63:0]; e.fin = 1'b1;
      cipher_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_beat_t e;
    if (!rst_ni) begin
      key_hi = '0;
      key_lo = '0;
      expand_schedule();
      cipher_q.delete();
      fail_count_o = 0;
      results_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == aes_tb_pkg::KeyHighIdx) key_hi = cfg_data_i;
        else key_lo = cfg_data_i;
        expand_schedule();
      end
      if (in_valid_i && in_ready_i)
        predict_ciphertext({block_high_i, block_low_i}, byte_count_i, last_block_i);
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (cipher_q.size() == 0) begin
          $error("unexpected output beat: cipher_high %h", cipher_high_i);
          fail_count_o++;
        end else begin
          e = cipher_q.pop_front();
          if (cipher_high_i !== e.hi) begin
            $error("cipher_high: expected %h, got %h", e.hi, cipher_high_i);
            fail_count_o++;
          end
          if (cipher_low_i !== e.lo) begin
            $error("cipher_low: expected %h, got %h", e.lo, cipher_low_i);
            fail_count_o++;
          end
          if (final_out_i !== e.fin) begin
            $error("final_out: expected %b, got %b", e.fin, final_out_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = cipher_q.size();
  end
endmodule

// ----- tb/aes128_ecb_pkcs7_encrypt_test.sv -----
// top of the aes-128 ecb pkcs7 testbench: clock, reset, key writes and beat traffic
// depends on aes128_ecb_pkcs7_encrypt and the checker file (aes_tb_pkg)
`timescale 1ns / 1ps
module aes128_ecb_pkcs7_encrypt_test;
  localparam int CycleLimit = 300000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = aes_tb_pkg::KeyHighIdx;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic [4:0] byte_count_i = '0;
  logic last_block_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [63:0] cipher_high_o, cipher_low_o;
  logic final_out_o;

  int fail_count, pending, results;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int blocks_sent = 0;
  int messages = 0;

  aes128_ecb_pkcs7_encrypt DUT (.*);

  aes128_ecb_pkcs7_check checker_inst (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .block_high_i, .block_low_i, .byte_count_i, .last_block_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .cipher_high_i(cipher_high_o), .cipher_low_i(cipher_low_o), .final_out_i(final_out_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request so the pipe backs up
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one input beat; called at a falling edge, returns at a falling edge
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] cnt, input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    block_high_i = hi;
    block_low_i = lo;
    byte_count_i = cnt;
    last_block_i = last;
    forever begin
      #1;
      if (in_ready_o) begin
        @(negedge clk_i);
        break;
      end
      @(negedge clk_i);
    end
    blocks_sent++;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    // no blocks remain in flight once pending is zero; this only adds idle time
    repeat (30) @(negedge clk_i);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    cfg_we_i = 1'b1;
    cfg_idx_i = aes_tb_pkg::KeyHighIdx;
    cfg_data_i = hi;
    @(negedge clk_i);
    cfg_idx_i = aes_tb_pkg::KeyLowIdx;
    cfg_data_i = lo;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // a message: some full blocks, then a last block with a random count
  task automatic send_message();
    int nblk;
    logic [4:0] cnt;
    nblk = $urandom_range(5);
    repeat (nblk) send_block(rand_word(), rand_word(), 5'($urandom), 1'b0);
    case ($urandom_range(9))
      0: cnt = 5'd16;
      1: cnt = 5'd0;
      2: cnt = 5'($urandom_range(31, 17));
      default: cnt = 5'($urandom_range(16));
    endcase
    send_block(rand_word(), rand_word(), cnt, 1'b1);
    messages++;
  endtask

  initial begin
    logic [4:0] dir_counts[8];
    dir_counts = '{5'd0, 5'd1, 5'd8, 5'd15, 5'd16, 5'd17, 5'd31, 5'd3};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset (all-zero) key, field extremes, every count corner
    send_block('0, '0, 5'd0, 1'b0);
    send_block('1, '1, 5'd31, 1'b0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b0);
    foreach (dir_counts[i]) send_block('1, '1, dir_counts[i], 1'b1);
    foreach (dir_counts[i]) send_block('0, 64'h0123456789abcdef, dir_counts[i], 1'b1);
    drain();

    // standard test key, sender mostly busy, receiver mostly stalled
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd0, 1'b0);
    tx_idle_pct = 26;
    rx_idle_pct = 74;
    for (int m = 0; m < 130; m++) begin
      if (m == 60) begin
        tx_idle_pct = 0;
        hold_req = 1'b1;
      end
      if (m == 80) tx_idle_pct = 26;
      send_message();
    end
    drain();

    // all-ones key, roles swapped; a full pause midway until the pipe is empty
    set_key('1, '1);
    tx_idle_pct = 74;
    rx_idle_pct = 26;
    for (int m = 0; m < 130; m++) begin
      if (m == 65) begin
        in_valid_i = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      send_message();
    end
    drain();

    // random key, back to back on both sides
    set_key({$urandom, $urandom}, {$urandom, $urandom});
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int m = 0; m < 125; m++) send_message();
    drain();

    $display("%0d blocks in %0d messages under 4 keys, %0d ciphertext beats checked",
             blocks_sent, messages, results);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- aes128_ecb_pkcs7_encrypt.f -----
+incdir+src
src/aes_pkg.sv
src/aes_key_exp.sv
src/aes_round_stage.sv
src/aes128_ecb_pkcs7_encrypt.sv
tb/aes128_ecb_pkcs7_check.sv
tb/aes128_ecb_pkcs7_encrypt_test.sv
